// ===== design/fbnp_pkg.sv =====
// ============================================================================
// fbnp_pkg
// Shared types and fixed constants of the file block node path lookup.
// ============================================================================
package fbnp_pkg;

    localparam int IN_W       = 32;
    localparam int DEPTH_W    = 2;
    localparam int SLOT_W     = 10;
    localparam int SEQ_W      = 19;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [2:0] {
        REG_INODE = 3'd0,
        REG_DIR1  = 3'd1,
        REG_DIR2  = 3'd2,
        REG_IND1  = 3'd3,
        REG_IND2  = 3'd4,
        REG_DIND  = 3'd5,
        REG_OOR   = 3'd6
    } t_region;

    localparam logic [DEPTH_W-1:0] DEPTH_INODE = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_DIR   = 2'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_IND   = 2'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_DIND  = 2'd3;

    // fixed node numbers along the tree
    localparam logic [SEQ_W-1:0] SEQ_DIR1      = 19'd1;
    localparam logic [SEQ_W-1:0] SEQ_DIR2      = 19'd2;
    localparam logic [SEQ_W-1:0] SEQ_IND1      = 19'd3;
    localparam logic [SEQ_W-1:0] SEQ_IND1_LEAF = 19'd4;

    // pointer code offsets from the base
    localparam logic [SLOT_W-1:0] PC_DIR1 = 10'd0;
    localparam logic [SLOT_W-1:0] PC_DIR2 = 10'd1;
    localparam logic [SLOT_W-1:0] PC_IND1 = 10'd2;
    localparam logic [SLOT_W-1:0] PC_IND2 = 10'd3;
    localparam logic [SLOT_W-1:0] PC_DIND = 10'd4;

endpackage

// ===== design/file_block_node_path.sv =====
// ============================================================================
// file_block_node_path
// Maps a logical file block index to its path through the inode pointer tree:
// depth, slot per level and node sequence numbers along the path.
// ============================================================================
//  channel   dir  tdata fields (low bit first)
//  s_axis    in   block_index[31:0]
//  m_axis    out  depth, out_of_range, slot_level0..3, node_seq_level1..3
//
//  Eight register stages: region classify, two constant dividers of three
//  stages each, field assembly into the output register.
//  One transfer per cycle sustained while m_axis_tready holds; each result
//  passes through every stage register in order before output valid.
//  Each stage has its own valid bit and loads when empty or draining, so a
//  stalled output fills bubbles before backpressure reaches s_axis.
//  Reset clears the valid bits only.
// ============================================================================
module file_block_node_path #(
    parameter int ADDRS_IN_INODE    = 512,
    parameter int ADDRS_PER_NODE    = 512,
    parameter int PTRS_PER_NODE     = 512,
    parameter int POINTER_CODE_BASE = 513
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // block_index[31:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // depth[1:0], out_of_range[2], slot_level0[12:3], slot_level1[22:13],
    // slot_level2[32:23], slot_level3[42:33], node_seq_level1[61:43],
    // node_seq_level2[80:62], node_seq_level3[99:81], zero[103:100]
    output logic [103:0] m_axis_tdata
);

    localparam int SW = fbnp_pkg::SLOT_W;
    localparam int QW = fbnp_pkg::SEQ_W;
    localparam int DEPTH_W_L = fbnp_pkg::DEPTH_W;

    localparam logic [63:0] DIR_SPAN  = 64'(ADDRS_PER_NODE);
    localparam logic [63:0] IND_SPAN  = DIR_SPAN * 64'(PTRS_PER_NODE);
    localparam logic [63:0] DIND_SPAN = IND_SPAN * 64'(PTRS_PER_NODE);
    localparam logic [63:0] B_DIR1    = 64'(ADDRS_IN_INODE);
    localparam logic [63:0] B_DIR2    = B_DIR1 + DIR_SPAN;
    localparam logic [63:0] B_IND1    = B_DIR2 + DIR_SPAN;
    localparam logic [63:0] B_IND2    = B_IND1 + IND_SPAN;
    localparam logic [63:0] B_DIND    = B_IND2 + IND_SPAN;
    localparam logic [63:0] B_END     = B_DIND + DIND_SPAN;

    localparam int RW1 = $clog2(ADDRS_PER_NODE);
    localparam int RW2 = $clog2(PTRS_PER_NODE);
    localparam int RGW = $bits(fbnp_pkg::t_region);
    localparam int SIDE1_W = RGW + SW;
    localparam int SIDE2_W = RGW + 3 * SW;

    localparam logic [SW-1:0] PCB        = SW'(POINTER_CODE_BASE);
    localparam logic [QW-1:0] SEQ_IND2   = QW'(4 + PTRS_PER_NODE);
    localparam logic [QW-1:0] SEQ_IND2_B = QW'(5 + PTRS_PER_NODE);
    localparam logic [QW-1:0] SEQ_DIND   = QW'(5 + 2 * PTRS_PER_NODE);
    localparam logic [QW-1:0] SEQ_DIND_B = QW'(6 + 2 * PTRS_PER_NODE);
    localparam logic [10:0]   PP1        = 11'(PTRS_PER_NODE + 1);

    // stage 1: classify
    logic                 r_s1_valid;
    logic                 rdy1;
    logic [31:0]          r_s1_off;
    fbnp_pkg::t_region    r_s1_region;
    logic [SW-1:0]        r_s1_s0;
    logic [31:0]          n_s1_off;
    fbnp_pkg::t_region    n_s1_region;
    logic [SW-1:0]        n_s1_s0;
    logic [63:0]          blk64;

    // divider links
    logic                 d1_ready, d1_valid, d2_ready, d2_valid;
    logic [31:0]          d1_quot, d2_quot;
    logic [RW1-1:0]       d1_rem;
    logic [RW2-1:0]       d2_rem;
    logic [SIDE1_W-1:0]   d1_side;
    logic [SIDE2_W-1:0]   d2_side_in, d2_side;

    // output stage
    logic                 r_out_valid;
    logic                 rdy_out;
    logic [103:0]         r_out_data;
    logic [103:0]         n_out_data;

    fbnp_pkg::t_region    o_region;
    logic [SW-1:0]        o_s0, o_q1, o_r1, o_q2, o_r2;
    logic [20:0]          o_mul;
    logic [DEPTH_W_L-1:0] n_depth;
    logic                 n_oor;
    logic [SW-1:0]        n_s0, n_s1, n_s2, n_s3;
    logic [QW-1:0]        n_q1, n_q2, n_q3;

    assign blk64 = {32'd0, s_axis_tdata};

    always_comb begin
        priority if (blk64 < B_DIR1) begin
            n_s1_region = fbnp_pkg::REG_INODE;
            n_s1_off    = s_axis_tdata;
            n_s1_s0     = s_axis_tdata[SW-1:0];
        end else if (blk64 < B_DIR2) begin
            n_s1_region = fbnp_pkg::REG_DIR1;
            n_s1_off    = s_axis_tdata - B_DIR1[31:0];
            n_s1_s0     = PCB + fbnp_pkg::PC_DIR1;
        end else if (blk64 < B_IND1) begin
            n_s1_region = fbnp_pkg::REG_DIR2;
            n_s1_off    = s_axis_tdata - B_DIR2[31:0];
            n_s1_s0     = PCB + fbnp_pkg::PC_DIR2;
        end else if (blk64 < B_IND2) begin
            n_s1_region = fbnp_pkg::REG_IND1;
            n_s1_off    = s_axis_tdata - B_IND1[31:0];
            n_s1_s0     = PCB + fbnp_pkg::PC_IND1;
        end else if (blk64 < B_DIND) begin
            n_s1_region = fbnp_pkg::REG_IND2;
            n_s1_off    = s_axis_tdata - B_IND2[31:0];
            n_s1_s0     = PCB + fbnp_pkg::PC_IND2;
        end else if (blk64 < B_END) begin
            n_s1_region = fbnp_pkg::REG_DIND;
            n_s1_off    = s_axis_tdata - B_DIND[31:0];
            n_s1_s0     = PCB + fbnp_pkg::PC_DIND;
        end else begin
            n_s1_region = fbnp_pkg::REG_OOR;
            n_s1_off    = 32'd0;
            n_s1_s0     = '0;
        end
    end

    assign rdy_out       = !r_out_valid || m_axis_tready;
    assign rdy1          = !r_s1_valid || d1_ready;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1)    r_s1_valid  <= s_axis_tvalid;
            if (rdy_out) r_out_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r_s1_off    <= n_s1_off;
            r_s1_region <= n_s1_region;
            r_s1_s0     <= n_s1_s0;
        end
        if (rdy_out && d2_valid) begin
            r_out_data <= n_out_data;
        end
    end

    // block offset split into node and slot
    fbnp_cdiv #(
        .DIVISOR (ADDRS_PER_NODE),
        .SIDE_W  (SIDE1_W),
        .REM_W   (RW1)
    ) u_div_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (d1_ready),
        .i_num   (r_s1_off),
        .i_side  ({r_s1_region, r_s1_s0}),
        .o_valid (d1_valid),
        .i_ready (d2_ready),
        .o_quot  (d1_quot),
        .o_rem   (d1_rem),
        .o_side  (d1_side)
    );

    assign d2_side_in = {d1_side, d1_quot[SW-1:0], SW'(d1_rem)};

    // node index split into indirect slot and pointer slot
    fbnp_cdiv #(
        .DIVISOR (PTRS_PER_NODE),
        .SIDE_W  (SIDE2_W),
        .REM_W   (RW2)
    ) u_div_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_valid),
        .o_ready (d2_ready),
        .i_num   (d1_quot),
        .i_side  (d2_side_in),
        .o_valid (d2_valid),
        .i_ready (rdy_out),
        .o_quot  (d2_quot),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    assign o_region = fbnp_pkg::t_region'(d2_side[SIDE2_W-1 -: RGW]);
    assign o_s0     = d2_side[3*SW-1 -: SW];
    assign o_q1     = d2_side[2*SW-1 -: SW];
    assign o_r1     = d2_side[SW-1:0];
    assign o_q2     = d2_quot[SW-1:0];
    assign o_r2     = SW'(d2_rem);
    assign o_mul    = 21'(o_q2) * 21'(PP1);

    always_comb begin
        n_depth = fbnp_pkg::DEPTH_INODE;
        n_oor   = 1'b0;
        n_s0    = o_s0;
        n_s1    = '0;
        n_s2    = '0;
        n_s3    = '0;
        n_q1    = '0;
        n_q2    = '0;
        n_q3    = '0;
        unique case (o_region)
            fbnp_pkg::REG_INODE: begin
                n_depth = fbnp_pkg::DEPTH_INODE;
            end
            fbnp_pkg::REG_DIR1: begin
                n_depth = fbnp_pkg::DEPTH_DIR;
                n_q1    = fbnp_pkg::SEQ_DIR1;
                n_s1    = o_r1;
            end
            fbnp_pkg::REG_DIR2: begin
                n_depth = fbnp_pkg::DEPTH_DIR;
                n_q1    = fbnp_pkg::SEQ_DIR2;
                n_s1    = o_r1;
            end
            fbnp_pkg::REG_IND1: begin
                n_depth = fbnp_pkg::DEPTH_IND;
                n_q1    = fbnp_pkg::SEQ_IND1;
                n_s1    = o_q1;
                n_q2    = fbnp_pkg::SEQ_IND1_LEAF + QW'(o_q1);
                n_s2    = o_r1;
            end
            fbnp_pkg::REG_IND2: begin
                n_depth = fbnp_pkg::DEPTH_IND;
                n_q1    = SEQ_IND2;
                n_s1    = o_q1;
                n_q2    = SEQ_IND2_B + QW'(o_q1);
                n_s2    = o_r1;
            end
            fbnp_pkg::REG_DIND: begin
                n_depth = fbnp_pkg::DEPTH_DIND;
                n_q1    = SEQ_DIND;
                n_s1    = o_q2;
                n_q2    = SEQ_DIND_B + o_mul[QW-1:0];
                n_s2    = o_r2;
                n_q3    = SEQ_DIND_B + o_mul[QW-1:0] + QW'(1) + QW'(o_r2);
                n_s3    = o_r1;
            end
            default: begin
                n_oor   = 1'b1;
                n_s0    = '0;
            end
        endcase
    end

    assign n_out_data = {4'd0, n_q3, n_q2, n_q1, n_s3, n_s2, n_s1, n_s0, n_oor, n_depth};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== design/fbnp_cdiv.sv =====
// ============================================================================
// fbnp_cdiv
// Three-stage division of a 32-bit value by a constant: reciprocal multiply,
// back multiply, one compare-and-subtract correction. Sideband rides along.
// ============================================================================
module fbnp_cdiv #(
    parameter int DIVISOR = 512,
    parameter int SIDE_W  = 8,
    parameter int REM_W   = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_num,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_quot,
    output logic [REM_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(DIVISOR);
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [31:0] DIV32      = 32'(DIVISOR);
    localparam logic [REM_W:0] DIV_R   = (REM_W+1)'(DIVISOR);

    logic              r_a_valid, r_b_valid, r_c_valid;
    logic              rdy_a, rdy_b, rdy_c;
    logic [31:0]       r_a_num, r_a_qest;
    logic [SIDE_W-1:0] r_a_side;
    logic [31:0]       r_b_num, r_b_qest, r_b_back;
    logic [SIDE_W-1:0] r_b_side;
    logic [31:0]       r_c_quot;
    logic [REM_W-1:0]  r_c_rem;
    logic [SIDE_W-1:0] r_c_side;

    logic [63:0]       n_a_prod;
    logic [63:0]       n_b_prod;
    logic [31:0]       n_c_diff;
    logic [REM_W:0]    n_c_raw;
    logic [31:0]       n_c_quot;
    logic [REM_W:0]    n_c_rem;

    assign rdy_c   = !r_c_valid || i_ready;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;

    assign n_a_prod = 64'(i_num) * 64'(RECIP);
    assign n_b_prod = 64'(r_a_qest) * 64'(DIV32);

    always_comb begin
        n_c_diff = r_b_num - r_b_back;
        n_c_raw  = n_c_diff[REM_W:0];
        if (n_c_raw >= DIV_R) begin
            n_c_quot = r_b_qest + 32'd1;
            n_c_rem  = n_c_raw - DIV_R;
        end else begin
            n_c_quot = r_b_qest;
            n_c_rem  = n_c_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (rdy_a) r_a_valid <= i_valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a_num  <= i_num;
            r_a_qest <= n_a_prod[63:32];
            r_a_side <= i_side;
        end
        if (rdy_b && r_a_valid) begin
            r_b_num  <= r_a_num;
            r_b_qest <= r_a_qest;
            r_b_back <= n_b_prod[31:0];
            r_b_side <= r_a_side;
        end
        if (rdy_c && r_b_valid) begin
            r_c_quot <= n_c_quot;
            r_c_rem  <= n_c_rem[REM_W-1:0];
            r_c_side <= r_b_side;
        end
    end

    assign o_valid = r_c_valid;
    assign o_quot  = r_c_quot;
    assign o_rem   = r_c_rem;
    assign o_side  = r_c_side;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the block index to node path lookup against a local path predictor.
// A queue of block indexes (region edges first, then random ones weighted
// over all tree regions and the full 32-bit range) is streamed in with random
// gaps and receiver stalls, including long receiver hold-offs that back the
// pipeline up to its input. Every result is compared field by field in order.
// ============================================================================
module testbench;

    localparam int AIN  = 512;
    localparam int DIR  = 512;
    localparam int PTRS = 512;
    localparam int PCB  = 513;

    localparam logic [63:0] IND_SPAN  = 64'(DIR) * 64'(PTRS);
    localparam logic [63:0] DIND_SPAN = IND_SPAN * 64'(PTRS);
    localparam logic [63:0] BASE_DIR1 = 64'(AIN);
    localparam logic [63:0] BASE_DIR2 = BASE_DIR1 + 64'(DIR);
    localparam logic [63:0] BASE_IND1 = BASE_DIR2 + 64'(DIR);
    localparam logic [63:0] BASE_IND2 = BASE_IND1 + IND_SPAN;
    localparam logic [63:0] BASE_DIND = BASE_IND2 + IND_SPAN;
    localparam logic [63:0] BASE_OOR  = BASE_DIND + DIND_SPAN;
    localparam int N_RANDOM = 1400;

    typedef struct packed {
        logic [fbnp_pkg::SEQ_W-1:0]   seq3;
        logic [fbnp_pkg::SEQ_W-1:0]   seq2;
        logic [fbnp_pkg::SEQ_W-1:0]   seq1;
        logic [fbnp_pkg::SLOT_W-1:0]  slot3;
        logic [fbnp_pkg::SLOT_W-1:0]  slot2;
        logic [fbnp_pkg::SLOT_W-1:0]  slot1;
        logic [fbnp_pkg::SLOT_W-1:0]  slot0;
        logic                         oor;
        logic [fbnp_pkg::DEPTH_W-1:0] depth;
    } t_node_path;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // block_index[31:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // depth, out_of_range, slot_level0..3, node_seq_level1..3

    logic [31:0]  index_queue[$];
    t_node_path   path_queue[$];
    int           mismatches;
    int           n_sent;
    int           n_seen;
    int           depth_count[4];
    int           oor_count;
    logic         hold_off;
    int           tx_idle;
    int           rx_idle;
    int           tx_mode;
    int           rx_mode;
    int           rx_cycles;
    t_node_path   got;
    t_node_path   want;

    file_block_node_path #(
        .ADDRS_IN_INODE    (AIN),
        .ADDRS_PER_NODE    (DIR),
        .PTRS_PER_NODE     (PTRS),
        .POINTER_CODE_BASE (PCB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_node_path node_path_of(input logic [31:0] block_index);
        t_node_path  p;
        logic [63:0] b;
        logic [63:0] dep, oor, s0, s1, s2, s3, q1, q2, q3;
        b   = 64'(block_index);
        dep = 0; oor = 0;
        s0 = 0; s1 = 0; s2 = 0; s3 = 0;
        q1 = 0; q2 = 0; q3 = 0;
        if (b < 64'(AIN)) begin
            s0 = b;
        end else begin
            b = b - 64'(AIN);
            if (b < 64'(DIR)) begin
                dep = 64'(fbnp_pkg::DEPTH_DIR);
                s0  = 64'(PCB) + 64'(fbnp_pkg::PC_DIR1);
                q1  = 64'(fbnp_pkg::SEQ_DIR1);
                s1  = b;
            end else if (b - 64'(DIR) < 64'(DIR)) begin
                dep = 64'(fbnp_pkg::DEPTH_DIR);
                s0  = 64'(PCB) + 64'(fbnp_pkg::PC_DIR2);
                q1  = 64'(fbnp_pkg::SEQ_DIR2);
                s1  = b - 64'(DIR);
            end else begin
                b = b - 2 * 64'(DIR);
                if (b < IND_SPAN) begin
                    dep = 64'(fbnp_pkg::DEPTH_IND);
                    s0  = 64'(PCB) + 64'(fbnp_pkg::PC_IND1);
                    q1  = 64'(fbnp_pkg::SEQ_IND1);
                    s1  = b / 64'(DIR);
                    q2  = 64'(fbnp_pkg::SEQ_IND1_LEAF) + s1;
                    s2  = b % 64'(DIR);
                end else if (b - IND_SPAN < IND_SPAN) begin
                    b   = b - IND_SPAN;
                    dep = 64'(fbnp_pkg::DEPTH_IND);
                    s0  = 64'(PCB) + 64'(fbnp_pkg::PC_IND2);
                    q1  = 4 + 64'(PTRS);
                    s1  = b / 64'(DIR);
                    q2  = 5 + 64'(PTRS) + s1;
                    s2  = b % 64'(DIR);
                end else if (b - 2 * IND_SPAN < DIND_SPAN) begin
                    b   = b - 2 * IND_SPAN;
                    dep = 64'(fbnp_pkg::DEPTH_DIND);
                    s0  = 64'(PCB) + 64'(fbnp_pkg::PC_DIND);
                    q1  = 5 + 2 * 64'(PTRS);
                    s1  = b / IND_SPAN;
                    q2  = 6 + 2 * 64'(PTRS) + s1 * (64'(PTRS) + 1);
                    s2  = (b / 64'(DIR)) % 64'(PTRS);
                    q3  = 7 + 2 * 64'(PTRS) + s1 * (64'(PTRS) + 1) + s2;
                    s3  = b % 64'(DIR);
                end else begin
                    oor = 1;
                end
            end
        end
        p.depth = dep[fbnp_pkg::DEPTH_W-1:0];
        p.oor   = oor[0];
        p.slot0 = s0[fbnp_pkg::SLOT_W-1:0];
        p.slot1 = s1[fbnp_pkg::SLOT_W-1:0];
        p.slot2 = s2[fbnp_pkg::SLOT_W-1:0];
        p.slot3 = s3[fbnp_pkg::SLOT_W-1:0];
        p.seq1  = q1[fbnp_pkg::SEQ_W-1:0];
        p.seq2  = q2[fbnp_pkg::SEQ_W-1:0];
        p.seq3  = q3[fbnp_pkg::SEQ_W-1:0];
        return p;
    endfunction

    // random index inside one tree region, often right at its edges
    function automatic logic [31:0] index_in_region(input fbnp_pkg::t_region rgn);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] pick;
        int          r;
        case (rgn)
            fbnp_pkg::REG_INODE: begin lo = 0;         hi = BASE_DIR1 - 1; end
            fbnp_pkg::REG_DIR1:  begin lo = BASE_DIR1; hi = BASE_DIR2 - 1; end
            fbnp_pkg::REG_DIR2:  begin lo = BASE_DIR2; hi = BASE_IND1 - 1; end
            fbnp_pkg::REG_IND1:  begin lo = BASE_IND1; hi = BASE_IND2 - 1; end
            fbnp_pkg::REG_IND2:  begin lo = BASE_IND2; hi = BASE_DIND - 1; end
            fbnp_pkg::REG_DIND:  begin lo = BASE_DIND; hi = BASE_OOR - 1;  end
            default:             begin lo = BASE_OOR;  hi = 64'hFFFF_FFFF; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 12)
            pick = lo + 64'($urandom_range(0, 3));
        else if (r < 24)
            pick = hi - 64'($urandom_range(0, 3));
        else
            pick = lo + 64'($urandom) % (hi - lo + 1);
        return pick[31:0];
    endfunction

    function automatic int gap_len(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (mode == 2 && r >= 96)
            return $urandom_range(20, 60);
        return $urandom_range(4, 10);
    endfunction

    initial begin
        logic [31:0]       edges[$];
        int                r;
        fbnp_pkg::t_region rgn;
        i_rst_n <= 1'b0;
        edges = '{32'd0, 32'd1, 32'd511, 32'd512, 32'd1023, 32'd1024, 32'd1535,
                  32'd1536, BASE_IND1[31:0] + 32'd513, BASE_IND2[31:0] - 32'd1,
                  BASE_IND2[31:0], BASE_DIND[31:0] - 32'd1, BASE_DIND[31:0],
                  BASE_DIND[31:0] + IND_SPAN[31:0], BASE_OOR[31:0] - 32'd1,
                  BASE_OOR[31:0], 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                  32'h5555_5555, 32'hAAAA_AAAA};
        foreach (edges[k])
            index_queue.push_back(edges[k]);
        for (int k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10)      rgn = fbnp_pkg::REG_INODE;
            else if (r < 18) rgn = fbnp_pkg::REG_DIR1;
            else if (r < 26) rgn = fbnp_pkg::REG_DIR2;
            else if (r < 40) rgn = fbnp_pkg::REG_IND1;
            else if (r < 54) rgn = fbnp_pkg::REG_IND2;
            else if (r < 80) rgn = fbnp_pkg::REG_DIND;
            else             rgn = fbnp_pkg::REG_OOR;
            if (r >= 88)
                index_queue.push_back($urandom);
            else
                index_queue.push_back(index_in_region(rgn));
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // long receiver hold-offs so the pipeline backs up to its input
    initial begin
        hold_off <= 1'b0;
        wait (n_seen >= 200);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_off <= 1'b0;
        wait (n_seen >= 900);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_idle       <= 0;
            tx_mode       <= 1;
            n_sent        <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                path_queue.push_back(node_path_of(s_axis_tdata));
                void'(index_queue.pop_front());
                n_sent <= n_sent + 1;
                if (n_sent % 100 == 99)
                    tx_mode <= $urandom_range(0, 2);
            end
            if (tx_idle != 0 && !hold_off) begin
                s_axis_tvalid <= 1'b0;
                tx_idle       <= tx_idle - 1;
            end else if (index_queue.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= index_queue[0];
                tx_idle       <= gap_len(tx_mode);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_idle       <= 0;
            rx_mode       <= 0;
            rx_cycles     <= 0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles % 64 == 63)
                rx_mode <= $urandom_range(0, 2);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (rx_idle != 0) begin
                m_axis_tready <= 1'b0;
                rx_idle       <= rx_idle - 1;
            end else begin
                m_axis_tready <= 1'b1;
                rx_idle       <= gap_len(rx_mode);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mismatches <= 0;
            n_seen     <= 0;
            oor_count  <= 0;
            for (int k = 0; k < 4; k++)
                depth_count[k] <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[99:0];
            n_seen <= n_seen + 1;
            if (path_queue.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected transfer: got %h", got);
                mismatches <= mismatches + 1;
            end else begin
                want = path_queue.pop_front();
                if (want.oor)
                    oor_count <= oor_count + 1;
                else
                    depth_count[want.depth] <= depth_count[want.depth] + 1;
                if (got.depth !== want.depth || got.oor !== want.oor ||
                    got.slot0 !== want.slot0 || got.slot1 !== want.slot1 ||
                    got.slot2 !== want.slot2 || got.slot3 !== want.slot3 ||
                    got.seq1 !== want.seq1 || got.seq2 !== want.seq2 ||
                    got.seq3 !== want.seq3) begin
                    if (mismatches < 10) begin
                        $display("mismatch at result %0d", n_seen);
                        $display("  exp depth=%0d oor=%0d slots=%0d,%0d,%0d,%0d seq=%0d,%0d,%0d",
                                 want.depth, want.oor, want.slot0, want.slot1, want.slot2,
                                 want.slot3, want.seq1, want.seq2, want.seq3);
                        $display("  got depth=%0d oor=%0d slots=%0d,%0d,%0d,%0d seq=%0d,%0d,%0d",
                                 got.depth, got.oor, got.slot0, got.slot1, got.slot2,
                                 got.slot3, got.seq1, got.seq2, got.seq3);
                    end
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        while (index_queue.size() != 0 || s_axis_tvalid || path_queue.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d lookups checked: %0d inode, %0d direct, %0d indirect,",
                 n_seen, depth_count[0], depth_count[1], depth_count[2]);
        $display("%0d double indirect, %0d out of range; two long receiver hold-offs",
                 depth_count[3], oor_count);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && path_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d of %0d results seen", n_seen, n_sent);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fbnp_pkg.sv
design/fbnp_cdiv.sv
design/file_block_node_path.sv
dv/testbench.sv
